// ----- src/psw_pkg.sv -----
// shared types and constants for the packet sequence window placer
package psw_pkg;

   localparam int SLOTS_DEFAULT   = 1024;
   localparam int BUFFERS_DEFAULT = 4;
   localparam int QUEUE_DEPTH     = 2;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SWITCH_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BAD_LIMIT        = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_RUN_LENGTH  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_TRY_LIMIT   = 2'd3;

   localparam logic [10:0] SWITCH_THRESHOLD_RESET = 11'd716;
   localparam logic [15:0] BAD_LIMIT_RESET        = 16'd768;
   localparam logic [3:0]  SYNC_RUN_LENGTH_RESET  = 4'd3;
   localparam logic [11:0] SYNC_TRY_LIMIT_RESET   = 12'd1024;

   localparam logic [2:0] VERDICT_SEARCHING = 3'd0;
   localparam logic [2:0] VERDICT_PLACED    = 3'd1;
   localparam logic [2:0] VERDICT_DUPLICATE = 3'd2;
   localparam logic [2:0] VERDICT_OUT       = 3'd3;
   localparam logic [2:0] VERDICT_RESTART   = 3'd4;
   localparam logic [2:0] VERDICT_FAILED    = 3'd5;

   typedef struct packed {
      logic [2:0]  verdict;
      logic [31:0] extended_sequence;
      logic [1:0]  target_buffer;
      logic [9:0]  slot_index;
      logic        handed_off;
      logic [1:0]  handoff_buffer;
      logic [10:0] handoff_lost;
      logic [15:0] bad_total;
   } result_type;

endpackage

// ----- src/psw_front.sv -----
// front end: accepts headers and extends the sequence with the wrap count
module psw_front (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_sequence_number,
   input  logic        queue_full,
   output logic        push,
   output logic [31:0] push_ext
);
   import psw_pkg::*;

   logic [15:0] wrap_count_ff;
   logic [15:0] wrap_count_in;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      wrap_count_in = wrap_count_ff;
      if (req_sequence_number == 16'hFFFF) begin
         wrap_count_in = wrap_count_ff + 16'd1;
      end
   end

   assign push_ext = {wrap_count_in, req_sequence_number};

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_count_ff <= '0;
      end else if (push) begin
         wrap_count_ff <= wrap_count_in;
      end
   end

endmodule

// ----- src/psw_queue.sv -----
// short queue between front and back end
module psw_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic [31:0] push_data,
   output logic        full,
   input  logic        pop,
   output logic        valid,
   output logic [31:0] data
);
   import psw_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [31:0]   entry_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign full  = count_ff == CW'(QUEUE_DEPTH);
   assign valid = count_ff != '0;
   assign data  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

// ----- src/psw_back.sv -----
// back end: sync search, window placement, hand-off and slot flag sweeps
module psw_back #(
   parameter int SLOTS   = psw_pkg::SLOTS_DEFAULT,
   parameter int BUFFERS = psw_pkg::BUFFERS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [psw_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [psw_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   input  logic                                 q_valid,
   input  logic [31:0]                          q_ext,
   output logic                                 q_pop,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output psw_pkg::result_type                  rsp_out
);
   import psw_pkg::*;

   localparam int SW    = $clog2(SLOTS);
   localparam int FW    = $clog2(SLOTS + 1);
   localparam int BW    = $clog2(BUFFERS);
   localparam int DEPTH = BUFFERS * SLOTS;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_EVAL, S_CLEAR, S_LOOKUP, S_CHECK, S_HAND
   } state_type;

   state_type     state_ff, ret_ff;
   logic [10:0]   thr_ff;
   logic [15:0]   bad_lim_ff;
   logic [3:0]    run_len_ff;
   logic [11:0]   try_lim_ff;

   logic          synced_ff, have_last_ff, pend_ff;
   logic [3:0]    run_ff;
   logic [11:0]   try_ff;
   logic [31:0]   last_ff, base_ff, ext_ff;
   logic [BW-1:0] cur_ff, nb_ff, buf_ff;
   logic [SW-1:0] slot_ff;
   logic          oow_ff, in_cur_ff;
   logic [AW-1:0] addr_ff, clr_addr_ff, clr_last_ff;
   logic [FW-1:0] fill_cur_ff, fill_nb_ff;
   logic [15:0]   bad_ff;
   logic [2:0]    verdict_ff;
   logic          rsp_valid_ff;
   result_type    rsp_ff;

   logic          mem [DEPTH];
   logic          mem_q_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic          mem_wd;

   logic [31:0]   off;
   logic          in_cur_in, oow_in;
   logic [BW-1:0] buf_in, nb_new;
   logic [SW-1:0] slot_in;
   logic [AW-1:0] addr_in, reflag_base;
   logic [3:0]    run_in;
   logic          take, handoff;
   logic [15:0]   bad_inc;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out   = rsp_ff;
   assign take      = state_ff == S_IDLE && q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop     = take;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= SWITCH_THRESHOLD_RESET;
         bad_lim_ff <= BAD_LIMIT_RESET;
         run_len_ff <= SYNC_RUN_LENGTH_RESET;
         try_lim_ff <= SYNC_TRY_LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SWITCH_THRESHOLD: thr_ff     <= csr_data[10:0];
            CSR_BAD_LIMIT:        bad_lim_ff <= csr_data;
            CSR_SYNC_RUN_LENGTH:  run_len_ff <= csr_data[3:0];
            CSR_SYNC_TRY_LIMIT:   try_lim_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   // window classification
   always_comb begin
      off       = ext_ff - base_ff;
      in_cur_in = off < 32'(SLOTS);
      oow_in    = !(off < 32'(2 * SLOTS));
      buf_in    = in_cur_in ? cur_ff : nb_ff;
      slot_in   = in_cur_in ? SW'(off) : SW'(off - 32'(SLOTS));
      addr_in   = AW'(AW'(buf_in) * AW'(SLOTS) + AW'(slot_in));
   end

   always_comb begin
      run_in = 4'd0;
      if (ext_ff - last_ff == 32'd1) begin
         run_in = (run_ff == 4'd15) ? 4'd15 : run_ff + 4'd1;
      end
   end

   assign bad_inc     = (bad_ff == 16'hFFFF) ? bad_ff : bad_ff + 16'd1;
   assign handoff     = fill_cur_ff == FW'(SLOTS) || 32'(fill_nb_ff) > 32'(thr_ff);
   assign nb_new      = (nb_ff == BW'(BUFFERS - 1)) ? '0 : nb_ff + BW'(1);
   assign reflag_base = AW'(AW'(nb_new) * AW'(SLOTS));

   always_comb begin
      mem_we = 1'b0;
      mem_wa = addr_ff;
      mem_wd = 1'b1;
      if (state_ff == S_CLEAR) begin
         mem_we = 1'b1;
         mem_wa = clr_addr_ff;
         mem_wd = 1'b0;
      end else if (state_ff == S_CHECK && !oow_ff && !mem_q_ff) begin
         mem_we = 1'b1;
      end
   end

   // slot filled flags
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem[addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ret_ff       <= S_IDLE;
         clr_addr_ff  <= '0;
         clr_last_ff  <= AW'(DEPTH - 1);
         synced_ff    <= 1'b0;
         have_last_ff <= 1'b0;
         pend_ff      <= 1'b0;
         run_ff       <= '0;
         try_ff       <= '0;
         last_ff      <= '0;
         base_ff      <= '0;
         cur_ff       <= '0;
         nb_ff        <= BW'(1);
         fill_cur_ff  <= '0;
         fill_nb_ff   <= '0;
         bad_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (take) begin
                  ext_ff   <= q_ext;
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               rsp_ff                   <= '0;
               rsp_ff.extended_sequence <= ext_ff;
               rsp_ff.bad_total         <= bad_ff;
               if (pend_ff) begin
                  pend_ff          <= 1'b0;
                  base_ff          <= ext_ff;
                  fill_cur_ff      <= '0;
                  fill_nb_ff       <= '0;
                  bad_ff           <= '0;
                  rsp_ff.bad_total <= '0;
                  rsp_ff.verdict   <= VERDICT_RESTART;
                  rsp_valid_ff     <= 1'b1;
                  clr_addr_ff      <= '0;
                  clr_last_ff      <= AW'(DEPTH - 1);
                  ret_ff           <= S_IDLE;
                  state_ff         <= S_CLEAR;
               end else if (synced_ff) begin
                  state_ff <= S_LOOKUP;
               end else if (!have_last_ff) begin
                  have_last_ff   <= 1'b1;
                  last_ff        <= ext_ff;
                  run_ff         <= '0;
                  try_ff         <= '0;
                  fill_cur_ff    <= '0;
                  fill_nb_ff     <= '0;
                  rsp_ff.verdict <= VERDICT_SEARCHING;
                  rsp_valid_ff   <= 1'b1;
                  clr_addr_ff    <= '0;
                  clr_last_ff    <= AW'(DEPTH - 1);
                  ret_ff         <= S_IDLE;
                  state_ff       <= S_CLEAR;
               end else if (try_ff >= try_lim_ff) begin
                  have_last_ff   <= 1'b0;
                  run_ff         <= '0;
                  try_ff         <= '0;
                  rsp_ff.verdict <= VERDICT_FAILED;
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= S_IDLE;
               end else begin
                  run_ff  <= run_in;
                  last_ff <= ext_ff;
                  try_ff  <= try_ff + 12'd1;
                  if (run_in < run_len_ff) begin
                     rsp_ff.verdict <= VERDICT_SEARCHING;
                     rsp_valid_ff   <= 1'b1;
                     state_ff       <= S_IDLE;
                  end else begin
                     synced_ff   <= 1'b1;
                     base_ff     <= ext_ff;
                     fill_cur_ff <= '0;
                     fill_nb_ff  <= '0;
                     bad_ff      <= '0;
                     clr_addr_ff <= '0;
                     clr_last_ff <= AW'(DEPTH - 1);
                     ret_ff      <= S_LOOKUP;
                     state_ff    <= S_CLEAR;
                  end
               end
            end
            S_CLEAR: begin
               if (clr_addr_ff == clr_last_ff) begin
                  state_ff <= ret_ff;
               end else begin
                  clr_addr_ff <= clr_addr_ff + AW'(1);
               end
            end
            S_LOOKUP: begin
               in_cur_ff <= in_cur_in;
               oow_ff    <= oow_in;
               buf_ff    <= buf_in;
               slot_ff   <= slot_in;
               addr_ff   <= addr_in;
               state_ff  <= S_CHECK;
            end
            S_CHECK: begin
               if (oow_ff) begin
                  verdict_ff <= VERDICT_OUT;
                  bad_ff     <= bad_inc;
               end else if (mem_q_ff) begin
                  verdict_ff <= VERDICT_DUPLICATE;
                  bad_ff     <= bad_inc;
               end else begin
                  verdict_ff <= VERDICT_PLACED;
                  if (in_cur_ff) begin
                     fill_cur_ff <= fill_cur_ff + FW'(1);
                  end else begin
                     fill_nb_ff <= fill_nb_ff + FW'(1);
                  end
               end
               state_ff <= S_HAND;
            end
            S_HAND: begin
               rsp_ff                   <= '0;
               rsp_ff.verdict           <= verdict_ff;
               rsp_ff.extended_sequence <= ext_ff;
               rsp_ff.bad_total         <= bad_ff;
               if (!oow_ff) begin
                  rsp_ff.target_buffer <= 2'(buf_ff);
                  rsp_ff.slot_index    <= 10'(slot_ff);
               end
               rsp_valid_ff <= 1'b1;
               if (bad_ff > bad_lim_ff) begin
                  pend_ff <= 1'b1;
               end
               state_ff <= S_IDLE;
               if (handoff) begin
                  rsp_ff.handed_off     <= 1'b1;
                  rsp_ff.handoff_buffer <= 2'(cur_ff);
                  rsp_ff.handoff_lost   <= 11'(FW'(SLOTS) - fill_cur_ff);
                  cur_ff      <= nb_ff;
                  nb_ff       <= nb_new;
                  fill_cur_ff <= fill_nb_ff;
                  fill_nb_ff  <= '0;
                  base_ff     <= base_ff + 32'(SLOTS);
                  clr_addr_ff <= reflag_base;
                  clr_last_ff <= reflag_base + AW'(SLOTS - 1);
                  ret_ff      <= S_IDLE;
                  state_ff    <= S_CLEAR;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- src/packet_sequence_window_placer_top.sv -----
// top level of the packet sequence window placer
// a placed result is registered in the hand-off state, a search result in the evaluate state
// the back end takes a new header only from idle and while its result output is not stalled
// a hand-off adds a re-flag sweep of the new next buffer before the next header is processed
// search start, sync start and restart add a sweep of all BUFFERS*SLOTS flags
// synchronous active-high reset; a full flag sweep follows; input stalls when the queue fills
module packet_sequence_window_placer_top #(
   parameter int SLOTS   = psw_pkg::SLOTS_DEFAULT,
   parameter int BUFFERS = psw_pkg::BUFFERS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [15:0]                         req_sequence_number,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_verdict,
   output logic [31:0]                         rsp_extended_sequence,
   output logic [1:0]                          rsp_target_buffer,
   output logic [9:0]                          rsp_slot_index,
   output logic                                rsp_handed_off,
   output logic [1:0]                          rsp_handoff_buffer,
   output logic [10:0]                         rsp_handoff_lost,
   output logic [15:0]                         rsp_bad_total,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [psw_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [psw_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import psw_pkg::*;

   logic        push, queue_full, q_valid, q_pop;
   logic [31:0] push_ext, q_ext;
   result_type  result;

   psw_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sequence_number (req_sequence_number),
      .queue_full          (queue_full),
      .push                (push),
      .push_ext            (push_ext)
   );

   psw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_ext),
      .full      (queue_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .data      (q_ext)
   );

   psw_back #(
      .SLOTS   (SLOTS),
      .BUFFERS (BUFFERS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_valid   (q_valid),
      .q_ext     (q_ext),
      .q_pop     (q_pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_out   (result)
   );

   assign rsp_verdict           = result.verdict;
   assign rsp_extended_sequence = result.extended_sequence;
   assign rsp_target_buffer     = result.target_buffer;
   assign rsp_slot_index        = result.slot_index;
   assign rsp_handed_off        = result.handed_off;
   assign rsp_handoff_buffer    = result.handoff_buffer;
   assign rsp_handoff_lost      = result.handoff_lost;
   assign rsp_bad_total         = result.bad_total;

endmodule

// ----- src/psw_checker.sv -----
// port checker for the packet sequence window placer and its bind
module psw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_verdict,
   input logic [1:0]  rsp_target_buffer,
   input logic [9:0]  rsp_slot_index,
   input logic        rsp_handed_off,
   input logic [1:0]  rsp_handoff_buffer,
   input logic [10:0] rsp_handoff_lost
);
   import psw_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_verdict))
      else $error("stalled result changed");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict != VERDICT_PLACED && rsp_verdict != VERDICT_DUPLICATE
      |-> rsp_target_buffer == '0 && rsp_slot_index == '0)
      else $error("slot given for unplaced packet");

   a_handoff_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_handed_off |-> rsp_handoff_buffer == '0 && rsp_handoff_lost == '0)
      else $error("hand-off fields set without hand-off");

endmodule

bind packet_sequence_window_placer_top psw_checker u_psw_checker (.*);
